>>> rtl/keyword_token_lexer_unit_assert.svh
// Assertion macros for the keyword token lexer.
// Included by the files that carry concurrent assertions; needs nothing else.
`ifndef KEYWORD_TOKEN_LEXER_UNIT_ASSERT_SVH
`define KEYWORD_TOKEN_LEXER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define KWL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define KWL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KWL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KWL_ASSERT(lbl, clk, rst_n, prop, msg)
`define KWL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define KWL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/kwl_pkg.sv
// Shared types and constants of the keyword token lexer.
// No dependencies; imported by the scanner, the result queue and the top level.
package kwl_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [7:0]  token_length;
        logic        run_last;
    } t_out_item;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_WORD   = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_ERROR  = 4'b1000
    } t_mode;

    localparam logic [3:0] KIND_VARIABLE = 4'd0;
    localparam logic [3:0] KIND_NUMBER   = 4'd1;
    localparam logic [3:0] KIND_INT      = 4'd2;
    localparam logic [3:0] KIND_ASSIGN   = 4'd7;
    localparam logic [3:0] KIND_ERROR    = 4'd13;

    localparam int NUM_KEYWORDS = 5;
    localparam int NUM_PUNCT    = 6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    // Keyword order: int, float, bool, true, false.
    localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{3'd3, 3'd5, 3'd4, 3'd4, 3'd5};

    // Order: = ; + - * /
    localparam logic [7:0] PUNCT_TEXT [NUM_PUNCT] =
        '{8'h3D, 8'h3B, 8'h2B, 8'h2D, 8'h2A, 8'h2F};

    // Character of keyword k at position idx; zero past its end.
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
        logic [39:0] text;
        case (k)
            0:       text = {"int", 16'h0};
            1:       text = "float";
            2:       text = {"bool", 8'h0};
            3:       text = {"true", 8'h0};
            default: text = "false";
        endcase
        case (idx)
            3'd0:    kw_char = text[39:32];
            3'd1:    kw_char = text[31:24];
            3'd2:    kw_char = text[23:16];
            3'd3:    kw_char = text[15:8];
            3'd4:    kw_char = text[7:0];
            default: kw_char = 8'h0;
        endcase
    endfunction

endpackage

>>> rtl/kwl_scanner.sv
// Scanner state and per-byte token logic of the keyword token lexer.
// Depends on kwl_pkg; gives up to two result items for each byte taken.
module kwl_scanner
    import kwl_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = 255,
    parameter int POSITION_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  t_in_item    i_item,
    output t_out_item   o_result0,
    output t_out_item   o_result1,
    output logic [1:0]  o_result_count
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int POS_W = POSITION_BITS;
    localparam int SW    = (POS_W > 16) ? POS_W : 16;
    localparam int LW    = (LEN_W > 8) ? LEN_W : 8;

    t_mode              r_mode,   n_mode;
    logic [POS_W-1:0]   r_start,  n_start;
    logic [LEN_W-1:0]   r_len,    n_len;
    logic [4:0]         r_flags,  n_flags;
    logic [POS_W-1:0]   r_pos,    n_pos;

    function automatic logic [4:0] flags_after(input logic [4:0] flags,
                                               input logic [LEN_W-1:0] idx,
                                               input logic [7:0] c);
        logic [4:0] f;
        f = flags;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (!(idx < LEN_W'(KW_LEN[k]) && c == kw_char(k, idx[2:0]))) begin
                f[k] = 1'b0;
            end
        end
        return f;
    endfunction

    function automatic logic [3:0] word_kind(input logic [4:0] flags,
                                             input logic [LEN_W-1:0] len);
        logic [3:0] kind;
        kind = KIND_VARIABLE;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (flags[k] && len == LEN_W'(KW_LEN[k])) begin
                kind = KIND_INT + 4'(k);
            end
        end
        return kind;
    endfunction

    function automatic t_out_item make_result(input logic [3:0] kind,
                                              input logic [POS_W-1:0] start,
                                              input logic [LEN_W-1:0] len);
        t_out_item r;
        logic [SW-1:0] s;
        logic [LW-1:0] l;
        s = SW'(start);
        l = LW'(len);
        r.token_kind   = kind;
        r.token_start  = (s > SW'(16'hFFFF)) ? 16'hFFFF : s[15:0];
        r.token_length = (l > LW'(8'hFF)) ? 8'hFF : l[7:0];
        r.run_last     = 1'b0;
        return r;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic       alpha, digit, space, taken;
        logic       close1, tok, close2;
        logic [3:0] punct_kind;
        t_out_item  res_close1, res_tok, res_close2;
        logic [LEN_W-1:0] len_ext;

        c     = i_item.byte_value;
        alpha = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        digit = (c inside {[8'h30:8'h39]});
        space = (c inside {[8'h09:8'h0D], CH_SPACE});
        len_ext = (r_len < LEN_W'(MAX_TOKEN_LENGTH)) ? r_len + LEN_W'(1) : r_len;

        n_mode  = r_mode;
        n_start = r_start;
        n_len   = r_len;
        n_flags = r_flags;
        taken   = 1'b0;
        close1  = 1'b0;
        tok     = 1'b0;
        close2  = 1'b0;

        // A pending token is closed with the state it had before this byte.
        res_close1 = make_result((r_mode == MODE_WORD) ? word_kind(r_flags, r_len)
                                                       : KIND_NUMBER, r_start, r_len);

        case (r_mode)
            MODE_ERROR: begin
                taken = 1'b1;
            end
            MODE_WORD: begin
                if (alpha || digit) begin
                    n_flags = flags_after(r_flags, r_len, c);
                    n_len   = len_ext;
                    taken   = 1'b1;
                end else begin
                    close1 = 1'b1;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_NUMBER: begin
                if (digit || c == CH_DOT) begin
                    n_len = len_ext;
                    taken = 1'b1;
                end else begin
                    close1 = 1'b1;
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
            end
        endcase

        punct_kind = KIND_ERROR;
        for (int k = 0; k < NUM_PUNCT; k++) begin
            if (c == PUNCT_TEXT[k]) begin
                punct_kind = KIND_ASSIGN + 4'(k);
            end
        end
        res_tok = make_result(punct_kind, r_pos, LEN_W'(1));

        if (!taken) begin
            if (alpha) begin
                n_mode  = MODE_WORD;
                n_start = r_pos;
                n_len   = LEN_W'(1);
                n_flags = flags_after(5'h1F, '0, c);
            end else if (digit) begin
                n_mode  = MODE_NUMBER;
                n_start = r_pos;
                n_len   = LEN_W'(1);
            end else if (!space) begin
                tok = 1'b1;
                if (punct_kind == KIND_ERROR) begin
                    n_mode = MODE_ERROR;
                end
            end
        end

        n_pos = (r_pos != '1) ? r_pos + POS_W'(1) : r_pos;

        res_close2 = make_result((n_mode == MODE_WORD) ? word_kind(n_flags, n_len)
                                                       : KIND_NUMBER, n_start, n_len);
        if (i_item.end_of_input) begin
            close2  = (n_mode inside {MODE_WORD, MODE_NUMBER});
            n_mode  = MODE_IDLE;
            n_start = '0;
            n_len   = '0;
            n_flags = 5'h1F;
            n_pos   = '0;
        end

        // A punctuation token and a closing at end of input never come together.
        o_result0 = close1 ? res_close1 : (tok ? res_tok : res_close2);
        o_result1 = tok ? res_tok : res_close2;
        o_result_count = 2'(close1) + 2'(tok) + 2'(close2);
        o_result0.run_last = (o_result_count == 2'd1);
        o_result1.run_last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_flags <= 5'h1F;
            r_pos   <= '0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_len   <= n_len;
            r_flags <= n_flags;
            r_pos   <= n_pos;
        end
    end

endmodule

>>> rtl/kwl_result_fifo.sv
// Four-entry result queue: takes up to two items a cycle, hands out one while the reader is ready.
// Depends on kwl_pkg for the result item type.
module kwl_result_fifo
    import kwl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_wr_count,
    input  t_out_item   i_wr_data0,
    input  t_out_item   i_wr_data1,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    output logic [2:0]  o_count
);

    localparam int DEPTH = 4;

    t_out_item   r_mem [DEPTH];
    logic [1:0]  r_wr_ptr, n_wr_ptr;
    logic [1:0]  r_rd_ptr, n_rd_ptr;
    logic [2:0]  r_count,  n_count;
    logic        w_pop;

    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_wr_count;
        n_rd_ptr = r_rd_ptr + 2'(w_pop);
        n_count  = r_count + 3'(i_wr_count) - 3'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr_data0;
        end
        if (i_wr_count == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_wr_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/keyword_token_lexer_unit.sv
// Keyword token lexer: one source byte per cycle in unless stalled, tokens out.
// Result items enter the result queue as their byte is taken and leave in order.
// Throughput: one byte per cycle while the four-entry result queue has two free
// slots; a byte that gives two tokens puts both into the queue.
// Synchronous active-low reset returns the scanner to idle and empties the queue.
`include "keyword_token_lexer_unit_assert.svh"
module keyword_token_lexer_unit
    import kwl_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = 255,
    parameter int POSITION_BITS    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    logic       w_take;
    t_out_item  w_result0, w_result1;
    logic [1:0] w_result_count;
    logic [1:0] w_wr_count;
    logic [2:0] w_fifo_count;

    // Room for the worst case of two items must be there before a byte is taken.
    assign o_in_ready = (w_fifo_count <= 3'd2);
    assign w_take     = i_in_valid && o_in_ready;
    assign w_wr_count = w_take ? w_result_count : 2'd0;

    kwl_scanner #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
        .POSITION_BITS    (POSITION_BITS)
    ) u_scanner (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_item         (i_in_item),
        .o_result0      (w_result0),
        .o_result1      (w_result1),
        .o_result_count (w_result_count)
    );

    kwl_result_fifo u_result_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_count (w_wr_count),
        .i_wr_data0 (w_result0),
        .i_wr_data1 (w_result1),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_item),
        .o_count    (w_fifo_count)
    );

    `KWL_ASSERT(a_queue_bound, i_clk, i_rst_n, w_fifo_count <= 3'd4, "result queue overflow")
    `KWL_ASSERT_NEXT(a_result_offered, i_clk, i_rst_n, w_take && w_result_count != 2'd0,
        o_out_valid, "taken byte gave no visible result")
    `KWL_ASSERT_IMPLY(a_run_last, i_clk, i_rst_n, w_result_count == 2'd2,
        !w_result0.run_last && w_result1.run_last, "run_last misplaced on a pair")

endmodule
